[rtl/tdfm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tdfm_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_SLOT  = 1'b1;

  localparam logic [1:0] KIND_AW = 2'd0;
  localparam logic [1:0] KIND_AR = 2'd1;
  localparam logic [1:0] KIND_DW = 2'd2;
  localparam logic [1:0] KIND_DR = 2'd3;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_INS   = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_WAIT  = 3'd5;
  localparam logic [2:0] PH_STOP  = 3'd6;

  localparam logic [15:0] WAIT_LIMIT_RESET = 16'd1000;
  localparam logic [15:0] WAIT_COUNT_MAX   = 16'hFFFF;
  localparam logic [31:0] READ_TIMEOUT_VAL = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        op;
    logic [1:0]  kind;
    logic [1:0]  len_code;
    logic [31:0] data;
    logic        sample;
  } tdfm_entry_t;

  typedef struct packed {
    logic        strobe_res;
    logic        data_drive;
    logic        drive_enable;
    logic        frame_done;
    logic        timed_out;
    logic [31:0] read_value;
    logic        busy_res;
  } tdfm_result_t;

endpackage

`default_nettype wire

[rtl/two_wire_debug_frame_master.sv]
// channel   | direction | handshake              | payload
// in        | input     | in_valid_i/in_ready_o   | op, frame_kind, byte_count, write_value,
//           |           |                        | line_sample
// out       | output    | out_valid_o/out_ready_i | strobe_res, data_drive, drive_enable,
//           |           |                        | frame_done, timed_out, read_value, busy_res
// cfg       | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (wait_slot_limit)
//
// one request per clock while downstream takes each result; a result passes through the queue
// and then the result register, and the engine stalls while a result waits for out_ready_i
// the frame engine updates its state once per request that it pops from the queue
// a small queue separates input accept from the engine, a result register holds the engine output
// reset clears the queue, phase and counters and loads the wait limit with 1000
// input stays ready while the queue has room, even with a result waiting downstream
`timescale 1ns / 1ps
`default_nettype none

module two_wire_debug_frame_master #(
  parameter int QueueDepth = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [15:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic         op_i,
  input  wire logic [1:0]   frame_kind_i,
  input  wire logic [2:0]   byte_count_i,
  input  wire logic [31:0]  write_value_i,
  input  wire logic         line_sample_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic              strobe_res_o,
  output logic              data_drive_o,
  output logic              drive_enable_o,
  output logic              frame_done_o,
  output logic              timed_out_o,
  output logic [31:0]       read_value_o,
  output logic              busy_res_o
);
  import tdfm_pkg::*;

  logic         push;
  logic         queue_ready;
  logic         queue_valid;
  logic         pop;
  tdfm_entry_t  push_entry;
  tdfm_entry_t  pop_entry;
  tdfm_result_t res;

  tdfm_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .frame_kind_i  (frame_kind_i),
    .byte_count_i  (byte_count_i),
    .write_value_i (write_value_i),
    .line_sample_i (line_sample_i),
    .push_o        (push),
    .entry_o       (push_entry),
    .queue_ready_i (queue_ready)
  );

  tdfm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .ready_o      (queue_ready),
    .valid_o      (queue_valid),
    .pop_entry_o  (pop_entry),
    .pop_i        (pop)
  );

  tdfm_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .entry_valid_i (queue_valid),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .res_o         (res)
  );

  assign strobe_res_o   = res.strobe_res;
  assign data_drive_o   = res.data_drive;
  assign drive_enable_o = res.drive_enable;
  assign frame_done_o   = res.frame_done;
  assign timed_out_o    = res.timed_out;
  assign read_value_o   = res.read_value;
  assign busy_res_o     = res.busy_res;

endmodule

`default_nettype wire

[rtl/tdfm_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tdfm_front (
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 op_i,
  input  wire logic [1:0]           frame_kind_i,
  input  wire logic [2:0]           byte_count_i,
  input  wire logic [31:0]          write_value_i,
  input  wire logic                 line_sample_i,
  output logic                      push_o,
  output tdfm_pkg::tdfm_entry_t     entry_o,
  input  wire logic                 queue_ready_i
);
  import tdfm_pkg::*;

  logic [31:0] data_init;

  // only write frames carry payload into the shifter
  always_comb begin
    case (frame_kind_i)
      KIND_AW: data_init = {24'd0, write_value_i[7:0]};
      KIND_DW: data_init = write_value_i;
      default: data_init = '0;
    endcase
  end

  always_comb begin
    entry_o.op       = op_i;
    entry_o.kind     = frame_kind_i;
    entry_o.len_code = byte_count_i[1:0] + 2'd3;
    entry_o.data     = data_init;
    entry_o.sample   = line_sample_i;
  end

  assign in_ready_o = queue_ready_i;
  assign push_o     = in_valid_i & queue_ready_i;

endmodule

`default_nettype wire

[rtl/tdfm_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module tdfm_queue #(
  parameter int Depth = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire tdfm_pkg::tdfm_entry_t push_entry_i,
  output logic                      ready_o,
  output logic                      valid_o,
  output tdfm_pkg::tdfm_entry_t     pop_entry_o,
  input  wire logic                 pop_i
);
  import tdfm_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  tdfm_entry_t         slots_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ready_o     = (count_q != CntW'(Depth));
  assign valid_o     = (count_q != '0);
  assign pop_entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && !ready_o))
    else $error("queue write while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && !valid_o))
    else $error("queue read while empty");

endmodule

`default_nettype wire

[rtl/tdfm_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module tdfm_engine (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [15:0]          cfg_data_i,
  input  wire logic                 entry_valid_i,
  input  wire tdfm_pkg::tdfm_entry_t entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output tdfm_pkg::tdfm_result_t    res_o
);
  import tdfm_pkg::*;

  logic [15:0]  limit_q;
  logic [2:0]   phase_q, phase_d;
  logic [1:0]   kind_q, kind_d;
  logic [1:0]   len_q, len_d;
  logic [5:0]   cnt_q, cnt_d;
  logic [31:0]  shift_q, shift_d;
  logic [15:0]  wcnt_q, wcnt_d;
  logic [1:0]   hist_q, hist_d;
  logic         out_valid_q;
  tdfm_result_t res_q, res_d;

  logic         is_read;
  logic         is_addr;
  logic [1:0]   ins_code;
  logic [5:0]   cnt_inc;
  logic [5:0]   data_bits;
  logic [1:0]   hist_new;
  logic [15:0]  wcnt_new;

  assign cfg_ready_o = 1'b1;
  assign pop_o       = entry_valid_i & (~out_valid_q | out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign is_read   = (kind_q == KIND_AR) || (kind_q == KIND_DR);
  assign is_addr   = (kind_q == KIND_AW) || (kind_q == KIND_AR);
  assign ins_code  = ~kind_q;
  assign cnt_inc   = cnt_q + 6'd1;
  assign data_bits = is_addr ? 6'd8 : ({1'b0, len_q, 3'b000} + 6'd8);
  assign hist_new  = {hist_q[0], entry_i.sample};
  assign wcnt_new  = (wcnt_q != WAIT_COUNT_MAX) ? wcnt_q + 16'd1 : wcnt_q;

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    wcnt_d  = wcnt_q;
    hist_d  = hist_q;
    res_d   = '0;
    if (entry_i.op == OP_START) begin
      kind_d  = entry_i.kind;
      len_d   = entry_i.len_code;
      shift_d = entry_i.data;
      cnt_d   = '0;
      wcnt_d  = '0;
      hist_d  = '0;
      phase_d = PH_START;
    end else if (phase_q != PH_IDLE) begin
      res_d.strobe_res = 1'b1;
      unique case (phase_q)
        PH_START: begin
          phase_d = PH_INS;
          cnt_d   = '0;
        end
        PH_INS: begin
          res_d.drive_enable = 1'b1;
          res_d.data_drive   = ins_code[cnt_q[0]];
          if (cnt_q == '0) begin
            cnt_d = 6'd1;
          end else begin
            cnt_d   = '0;
            phase_d = is_addr ? PH_DATA : PH_LEN;
          end
        end
        PH_LEN: begin
          res_d.drive_enable = 1'b1;
          res_d.data_drive   = len_q[cnt_q[0]];
          if (cnt_q == '0) begin
            cnt_d = 6'd1;
          end else begin
            cnt_d = '0;
            if (kind_q == KIND_DR) begin
              phase_d = PH_WAIT;
              wcnt_d  = '0;
              hist_d  = '0;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (is_read) begin
            shift_d = shift_q | (32'(entry_i.sample) << cnt_q[4:0]);
          end else begin
            res_d.drive_enable = 1'b1;
            res_d.data_drive   = shift_q[0];
            shift_d            = shift_q >> 1;
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= data_bits) begin
            cnt_d = '0;
            if (kind_q == KIND_DW) begin
              phase_d = PH_WAIT;
              wcnt_d  = '0;
              hist_d  = '0;
            end else begin
              phase_d = PH_STOP;
            end
          end
        end
        PH_WAIT: begin
          hist_d = hist_new;
          if (hist_new == 2'b01) begin
            cnt_d   = '0;
            phase_d = (kind_q == KIND_DR) ? PH_DATA : PH_STOP;
          end else begin
            wcnt_d = wcnt_new;
            if (wcnt_new >= limit_q) begin
              res_d.frame_done = 1'b1;
              res_d.timed_out  = 1'b1;
              res_d.read_value = is_read ? READ_TIMEOUT_VAL : '0;
              phase_d          = PH_IDLE;
            end
          end
        end
        default: begin
          res_d.frame_done = 1'b1;
          res_d.read_value = is_read ? shift_q : '0;
          phase_d          = PH_IDLE;
        end
      endcase
    end
    res_d.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= WAIT_LIMIT_RESET;
      phase_q     <= PH_IDLE;
      kind_q      <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      shift_q     <= '0;
      wcnt_q      <= '0;
      hist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (pop_o) begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        shift_q <= shift_d;
        wcnt_q  <= wcnt_d;
        hist_q  <= hist_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_done |-> !res_q.busy_res)
    else $error("frame end reported while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.timed_out |-> res_q.frame_done)
    else $error("timeout without frame end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.drive_enable |-> res_q.strobe_res)
    else $error("line driven without a strobe");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.read_value != '0) |-> res_q.frame_done)
    else $error("read data outside frame end");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && (phase_q == PH_IDLE) && (entry_i.op == OP_SLOT) |=> phase_q == PH_IDLE)
    else $error("idle slot left idle phase");

endmodule

`default_nettype wire
